[design/moesi_pkg.sv]
// ----------------------------------------------------------------------------
// MOESI line controller package
// Shared widths, codes and beat types for the single-line MOESI controller.
// ----------------------------------------------------------------------------
`default_nettype none

package moesi_pkg;

    localparam int TagBits  = 20;
    localparam int NodeBits = 4;
    localparam int CntBits  = 32;

    // Event codes carried in the cmd field. Code 7 is unused and changes nothing.
    typedef enum logic [2:0] {
        CMD_READ       = 3'd0,
        CMD_WRITE      = 3'd1,
        CMD_EVICT      = 3'd2,
        CMD_INVALIDATE = 3'd3,
        CMD_FETCH      = 3'd4,
        CMD_READ_DATA  = 3'd5,
        CMD_WRITE_DATA = 3'd6
    } cmd_t;

    // Coherence states of the line.
    typedef enum logic [2:0] {
        ST_I = 3'd0,
        ST_S = 3'd1,
        ST_E = 3'd2,
        ST_O = 3'd3,
        ST_M = 3'd4
    } line_state_t;

    // Bus messages that an event asks for.
    typedef enum logic [1:0] {
        MSG_NONE   = 2'd0,
        MSG_BUSRD  = 2'd1,
        MSG_BUSRDX = 2'd2,
        MSG_BCAST  = 2'd3
    } bus_msg_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic                write_flag;
        logic [TagBits-1:0]  new_tag;
        logic [NodeBits-1:0] requester_node;
        logic                exclusive;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]          bus_msg;
        logic [2:0]          line_state;
        logic                line_valid;
        logic                line_dirty;
        logic [TagBits-1:0]  line_tag;
        logic [NodeBits-1:0] owner_node;
        logic [CntBits-1:0]  hit_count;
        logic [CntBits-1:0]  miss_count;
        logic [CntBits-1:0]  eviction_count;
        logic [CntBits-1:0]  dirty_eviction_count;
        logic [CntBits-1:0]  invalidation_count;
        logic                fetch_error;
    } out_beat_t;

endpackage

`default_nettype wire

[design/moesi_line_state_machine.sv]
// ----------------------------------------------------------------------------
// MOESI line state machine
// Coherence controller for one cache line: takes one coherence event per
// beat and returns the bus message it needs plus a snapshot of the line.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Beat
//   s_       in         s_valid/s_ready    in_beat_t  (one coherence event)
//   m_       out        m_valid/m_ready    out_beat_t (message and snapshot)
//
// An event is captured in an input register; when the result register is free,
// the line update is computed from that register and written into the result
// register together with the line state and counters, and m_valid rises. One
// event can be taken every cycle while m_ready stays high. The rate is set by
// the single read-modify-write of the line state. Reset (aresetn low at a
// rising edge) empties both registers, sets the line to invalid and clears tag,
// owner, dirty mark and counters. When m_ready is low the result is held, the
// input register fills and then s_ready drops; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module moesi_line_state_machine
    import moesi_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,

    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,

    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    // Saturating increment: the counter stops at its all-ones value.
    function automatic logic [CntBits-1:0] sat_inc(input logic [CntBits-1:0] cnt,
                                                   input logic               en);
        logic [CntBits-1:0] res;
        res = cnt;
        if (en && (cnt != {CntBits{1'b1}})) begin
            res = cnt + {{(CntBits-1){1'b0}}, 1'b1};
        end
        return res;
    endfunction

    // Pipeline registers.
    logic        s1_valid_reg, s1_valid_next;
    in_beat_t    s1_data_reg;
    logic        m_valid_reg, m_valid_next;
    out_beat_t   m_data_reg, m_data_next;

    // Line state.
    line_state_t         state_reg, state_next;
    logic                dirty_reg, dirty_next;
    logic [TagBits-1:0]  tag_reg, tag_next;
    logic [NodeBits-1:0] node_reg, node_next;
    logic [CntBits-1:0]  hits_reg, hits_next;
    logic [CntBits-1:0]  misses_reg, misses_next;
    logic [CntBits-1:0]  evict_reg, evict_next;
    logic [CntBits-1:0]  dirty_evict_reg, dirty_evict_next;
    logic [CntBits-1:0]  inval_reg, inval_next;

    // Decode of the held event.
    logic        advance;
    logic        is_access;
    logic        acc_write;
    line_state_t acc_state;
    line_state_t acc_state_next;
    logic        acc_hit;
    bus_msg_t    bus_msg;
    logic        fetch_error;

    // The event in the input register moves on when the result slot is free.
    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_valid && s_ready) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // A read, write or evict-and-replace is an access. Evict-and-replace first
    // drops the line to invalid, so its access always starts from I.
    always_comb begin
        is_access = (s1_data_reg.cmd == CMD_READ) || (s1_data_reg.cmd == CMD_WRITE) ||
                    (s1_data_reg.cmd == CMD_EVICT);
        acc_write = (s1_data_reg.cmd == CMD_WRITE) ||
                    ((s1_data_reg.cmd == CMD_EVICT) && s1_data_reg.write_flag);
        acc_state = (s1_data_reg.cmd == CMD_EVICT) ? ST_I : state_reg;
        acc_hit   = (acc_state inside {ST_M, ST_O, ST_E}) ||
                    ((acc_state == ST_S) && !acc_write);
        case (acc_state)
            ST_M:    acc_state_next = ST_M;
            ST_O:    acc_state_next = ST_O;
            ST_E:    acc_state_next = acc_write ? ST_M : ST_E;
            ST_S:    acc_state_next = acc_write ? ST_M : ST_S;
            default: acc_state_next = acc_write ? ST_M : ST_E;
        endcase
    end

    // Next state of the line.
    always_comb begin
        state_next       = state_reg;
        dirty_next       = dirty_reg;
        tag_next         = tag_reg;
        node_next        = node_reg;
        evict_next       = evict_reg;
        dirty_evict_next = dirty_evict_reg;
        inval_next       = inval_reg;
        hits_next        = sat_inc(hits_reg, is_access && acc_hit);
        misses_next      = sat_inc(misses_reg, is_access && !acc_hit);
        case (s1_data_reg.cmd)
            CMD_READ: begin
                node_next  = s1_data_reg.requester_node;
                state_next = acc_state_next;
            end
            CMD_WRITE: begin
                dirty_next = 1'b1;
                node_next  = s1_data_reg.requester_node;
                state_next = acc_state_next;
            end
            CMD_EVICT: begin
                evict_next       = sat_inc(evict_reg, state_reg != ST_I);
                dirty_evict_next = sat_inc(dirty_evict_reg,
                                           (state_reg != ST_I) && dirty_reg);
                dirty_next       = s1_data_reg.write_flag;
                tag_next         = s1_data_reg.new_tag;
                node_next        = s1_data_reg.requester_node;
                state_next       = acc_state_next;
            end
            CMD_INVALIDATE: begin
                inval_next = sat_inc(inval_reg, 1'b1);
                state_next = ST_I;
            end
            CMD_FETCH: begin
                if (state_reg == ST_M) begin
                    state_next = ST_O;
                end else if (state_reg == ST_E) begin
                    state_next = ST_S;
                end
            end
            CMD_READ_DATA: begin
                state_next = s1_data_reg.exclusive ? ST_E : ST_S;
            end
            CMD_WRITE_DATA: begin
                state_next = ST_M;
            end
            default: begin
                state_next = state_reg;
            end
        endcase
    end

    // Outputs of the event: bus message and fetch error.
    always_comb begin
        bus_msg     = MSG_NONE;
        fetch_error = 1'b0;
        if (is_access) begin
            case (acc_state)
                ST_M:    bus_msg = MSG_NONE;
                ST_O:    bus_msg = acc_write ? MSG_BCAST : MSG_NONE;
                ST_E:    bus_msg = MSG_NONE;
                ST_S:    bus_msg = acc_write ? MSG_BUSRDX : MSG_NONE;
                default: bus_msg = acc_write ? MSG_BUSRDX : MSG_BUSRD;
            endcase
        end
        if (s1_data_reg.cmd == CMD_FETCH) begin
            fetch_error = !(state_reg inside {ST_M, ST_E, ST_O});
        end
    end

    // Snapshot of the line after the event.
    always_comb begin
        m_data_next.bus_msg              = bus_msg;
        m_data_next.line_state           = state_next;
        m_data_next.line_valid           = (state_next != ST_I);
        m_data_next.line_dirty           = dirty_next;
        m_data_next.line_tag             = tag_next;
        m_data_next.owner_node           = node_next;
        m_data_next.hit_count            = hits_next;
        m_data_next.miss_count           = misses_next;
        m_data_next.eviction_count       = evict_next;
        m_data_next.dirty_eviction_count = dirty_evict_next;
        m_data_next.invalidation_count   = inval_next;
        m_data_next.fetch_error          = fetch_error;
    end

    // Control and line state, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            state_reg       <= ST_I;
            dirty_reg       <= 1'b0;
            tag_reg         <= '0;
            node_reg        <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evict_reg       <= '0;
            dirty_evict_reg <= '0;
            inval_reg       <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                state_reg       <= state_next;
                dirty_reg       <= dirty_next;
                tag_reg         <= tag_next;
                node_reg        <= node_next;
                hits_reg        <= hits_next;
                misses_reg      <= misses_next;
                evict_reg       <= evict_next;
                dirty_evict_reg <= dirty_evict_next;
                inval_reg       <= inval_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    // The snapshot's valid flag agrees with its state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.line_valid == (m_data_reg.line_state != ST_I)))
        else $error("line_valid disagrees with line_state");

    // Every dirty eviction is also counted as an eviction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dirty_evict_reg <= evict_reg)
        else $error("dirty eviction count exceeds eviction count");

    // A fetch error comes with no bus message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.fetch_error) |-> (m_data_reg.bus_msg == MSG_NONE))
        else $error("fetch error with a bus message");

    // The line state moves only when an event is processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(advance)) |-> $stable(state_reg))
        else $error("line state changed without an event");

    // Hits rise by at most one per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ((hits_reg == $past(hits_reg)) ||
                            (hits_reg == $past(hits_reg) + CntBits'(1))))
        else $error("hit counter jumped");

endmodule

`default_nettype wire
